// ===== src/ccd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_pkg
// Shared constants and types of the control-change encoding detector.
// ----------------------------------------------------------------------------
package ccd_pkg;

   localparam int WINDOW      = 8;
   localparam int CONTROLLERS = 128;

   localparam int HEAD_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W     = $clog2(WINDOW + 1);
   localparam int CTL_W      = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1;
   localparam int CTL_DEPTH  = 1 << CTL_W;
   localparam int VADDR_W    = CTL_W + HEAD_W;
   localparam int VAL_DEPTH  = 1 << VADDR_W;

   typedef enum logic [2:0] {
      MODE_ABSOLUTE = 3'd0,
      MODE_VREL1    = 3'd1,
      MODE_VREL2    = 3'd2,
      MODE_VREL3    = 3'd3,
      MODE_MINMAX1  = 3'd4,
      MODE_MINMAX2  = 3'd5,
      MODE_BINOFF   = 3'd6,
      MODE_UNKNOWN  = 3'd7
   } ccd_mode_type;

   typedef struct packed {
      logic clear;
      logic take;
   } ccd_cls_ctl_type;

   typedef struct packed {
      logic [FILL_W-1:0] fill;
      logic [HEAD_W-1:0] head;
   } ccd_ctl_state_type;

endpackage
`default_nettype wire

// ===== src/midi_cc_encoding_detector_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Flow: an accepted word passes load, a scan of each stored value in its window
// (fill, 1..WINDOW, the window's count after the push), drain and finish; the
// result strobe is registered from finish. A controller beyond range goes
// straight to finish. No word is taken while busy. The shared compare unit sees
// one stored value per cycle from the single read port; results cannot stall.
// Reset clears all window counts at once through per-controller valid bits.
// ----------------------------------------------------------------------------
// midi_cc_encoding_detector_unit
// Keeps a sliding window per controller and reports the detected encoding.
// ----------------------------------------------------------------------------
module midi_cc_encoding_detector_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [6:0] req_controller,
   input  wire logic [6:0] req_cc_value,
   output logic            rsp_strobe,
   output logic      [6:0] rsp_controller_echo,
   output logic      [2:0] rsp_detected_mode
);
   import ccd_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_LOAD  = 5'b00010,
      S_SCAN  = 5'b00100,
      S_DRAIN = 5'b01000,
      S_FIN   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [6:0]        ctl_ff, val_ff;
   logic              unk_ff, unk_in;
   logic [FILL_W-1:0] n_ff, n_in;
   logic [FILL_W-1:0] idx_ff, idx_in;
   logic              rd_pend_ff;
   logic              rsp_strobe_ff;
   logic [6:0]        rsp_ctl_ff;
   logic [2:0]        rsp_mode_ff;

   ccd_ctl_state_type st_mem [CTL_DEPTH];
   ccd_ctl_state_type st_q_ff;
   logic              st_vld_ff;
   logic [CTL_DEPTH-1:0] valid_ff;

   logic              accept, ctl_ok;
   logic [CTL_W-1:0]  ctl_idx;
   logic [FILL_W-1:0] cur_fill, head_wide;
   logic [HEAD_W-1:0] cur_head;
   ccd_ctl_state_type st_new;
   logic              st_we;

   ccd_cls_ctl_type   cls_ctl;
   ccd_mode_type      cls_mode;
   logic [6:0]        rd_data;

   assign accept  = start && !busy;
   assign ctl_ok  = {1'b0, req_controller} < 8'(CONTROLLERS);
   assign ctl_idx = ctl_ff[CTL_W-1:0];
   assign busy    = (state_ff != S_IDLE);

   // A controller never written since reset starts from an empty window.
   always_comb begin
      cur_fill = st_vld_ff ? st_q_ff.fill : '0;
      cur_head = st_vld_ff ? st_q_ff.head : '0;
      head_wide = FILL_W'(cur_head) + FILL_W'(1);
      if (head_wide == FILL_W'(WINDOW)) begin
         head_wide = '0;
      end
      st_new.head = HEAD_W'(head_wide);
      st_new.fill = (cur_fill == FILL_W'(WINDOW)) ? cur_fill : cur_fill + FILL_W'(1);
      st_we = (state_ff == S_LOAD);
   end

   always_ff @(posedge clock) begin
      st_q_ff   <= st_mem[req_controller[CTL_W-1:0]];
      if (st_we) begin
         st_mem[ctl_idx] <= st_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (st_we) begin
         valid_ff[ctl_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         st_vld_ff <= valid_ff[req_controller[CTL_W-1:0]];
      end
   end

   ccd_window_mem u_window_mem (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr ({ctl_idx, cur_head}),
      .wr_data (val_ff),
      .rd_addr ({ctl_idx, idx_ff[HEAD_W-1:0]}),
      .rd_data (rd_data)
   );

   assign cls_ctl.clear = (state_ff == S_LOAD);
   assign cls_ctl.take  = rd_pend_ff;

   ccd_classify u_classify (
      .clock (clock),
      .ctl   (cls_ctl),
      .value (rd_data),
      .mode  (cls_mode)
   );

   always_comb begin
      state_in = state_ff;
      unk_in   = unk_ff;
      n_in     = n_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unk_in   = !ctl_ok;
               state_in = ctl_ok ? S_LOAD : S_FIN;
            end
         end
         S_LOAD: begin
            n_in     = st_new.fill;
            idx_in   = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            idx_in = idx_ff + FILL_W'(1);
            if (idx_ff + FILL_W'(1) == n_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_pend_ff    <= (state_ff == S_SCAN);
         rsp_strobe_ff <= (state_ff == S_FIN);
      end
   end

   always_ff @(posedge clock) begin
      unk_ff <= unk_in;
      n_ff   <= n_in;
      idx_ff <= idx_in;
      if (accept) begin
         ctl_ff <= req_controller;
         val_ff <= req_cc_value;
      end
      if (state_ff == S_FIN) begin
         rsp_ctl_ff  <= ctl_ff;
         rsp_mode_ff <= unk_ff ? MODE_UNKNOWN : cls_mode;
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_controller_echo = rsp_ctl_ff;
   assign rsp_detected_mode   = rsp_mode_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   a_strobe_from_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && $past(state_ff == S_FIN))
      else $error("result strobe without a finished word");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted word did not make the unit busy");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (idx_ff < n_ff) && (n_ff <= FILL_W'(WINDOW)))
      else $error("window scan ran past the fill count");

endmodule
`default_nettype wire

// ===== src/ccd_window_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_window_mem
// Value store for all controller windows, one write and one registered read.
// ----------------------------------------------------------------------------
module ccd_window_mem (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [ccd_pkg::VADDR_W-1:0] wr_addr,
   input  wire logic [6:0]                  wr_data,
   input  wire logic [ccd_pkg::VADDR_W-1:0] rd_addr,
   output logic      [6:0]                  rd_data
);
   import ccd_pkg::*;

   logic [6:0] mem [VAL_DEPTH];
   logic [6:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/ccd_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_classify
// Shared range-compare unit: folds one window word per cycle into rule flags
// and turns the flags into a mode by priority.
// ----------------------------------------------------------------------------
module ccd_classify (
   input  wire logic                     clock,
   input  wire ccd_pkg::ccd_cls_ctl_type ctl,
   input  wire logic [6:0]               value,
   output ccd_pkg::ccd_mode_type         mode
);
   import ccd_pkg::*;

   logic v1_ff, v2_ff, v3_ff, zero_ff, m1_ff, m2_ff, bo_ff;
   logic v1_in, v2_in, v3_in, zero_in, m1_in, m2_in, bo_in;
   logic is_zero, in_off;

   always_comb begin
      is_zero = (value == 7'd0);
      in_off  = (value >= 7'd63) && (value <= 7'd65);
      v1_in   = v1_ff && (is_zero || ((value >= 7'd61) && (value <= 7'd67)));
      v2_in   = v2_ff && (is_zero || ((value >= 7'd1) && (value <= 7'd3))
                                  || (value >= 7'd125));
      v3_in   = v3_ff && (is_zero || ((value >= 7'd12) && (value <= 7'd15))
                                  || ((value >= 7'd17) && (value <= 7'd19)));
      zero_in = zero_ff || is_zero;
      m1_in   = m1_ff && ((value == 7'd1) || (value == 7'd127));
      m2_in   = m2_ff && ((value == 7'd63) || (value == 7'd65));
      bo_in   = bo_ff && in_off;
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         v1_ff   <= 1'b1;
         v2_ff   <= 1'b1;
         v3_ff   <= 1'b1;
         zero_ff <= 1'b0;
         m1_ff   <= 1'b1;
         m2_ff   <= 1'b1;
         bo_ff   <= 1'b1;
      end else if (ctl.take) begin
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         v3_ff   <= v3_in;
         zero_ff <= zero_in;
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         bo_ff   <= bo_in;
      end
   end

   always_comb begin
      priority if (v1_ff && zero_ff) begin
         mode = MODE_VREL1;
      end else if (v2_ff && zero_ff) begin
         mode = MODE_VREL2;
      end else if (v3_ff && zero_ff) begin
         mode = MODE_VREL3;
      end else if (m1_ff) begin
         mode = MODE_MINMAX1;
      end else if (m2_ff) begin
         mode = MODE_MINMAX2;
      end else if (bo_ff) begin
         mode = MODE_BINOFF;
      end else begin
         mode = MODE_ABSOLUTE;
      end
   end

endmodule
`default_nettype wire
